// ===== src/acis_pkg.sv =====
// shared types, register codes and reset values for the a/c idle-up sequencer
// no dependencies
package acis_pkg;

    localparam int unsigned RpmW   = 16;
    localparam int unsigned TpsW   = 10;
    localparam int unsigned VssW   = 16;
    localparam int unsigned TickW  = 4;
    localparam int unsigned TimerW = 16;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned IdxW   = 3;
    localparam int unsigned InW    = 48;
    localparam int unsigned OutW   = 8;

    localparam logic [RpmW-1:0]   RstMinRpm   = 16'd400;
    localparam logic [RpmW-1:0]   RstMaxRpm   = 16'hFFFF;
    localparam logic [TpsW-1:0]   RstThrOff   = 10'd500;
    localparam logic [TpsW-1:0]   RstThrHyst  = 10'd20;
    localparam logic [VssW-1:0]   RstSpdOff   = 16'hFFFF;
    localparam logic [VssW-1:0]   RstSpdHyst  = 16'd0;
    localparam logic [TimerW-1:0] RstEngDelay = 16'd10;
    localparam logic [TimerW-1:0] RstRelock   = 16'd0;

    localparam logic [VssW-1:0]   SpeedDisabled = 16'hFFFF;
    localparam logic [TimerW-1:0] TimerMax      = 16'hFFFF;

    typedef enum logic [IdxW-1:0] {
        REG_MIN_RPM    = 3'd0,
        REG_MAX_RPM    = 3'd1,
        REG_THR_OFF    = 3'd2,
        REG_THR_HYST   = 3'd3,
        REG_SPD_OFF    = 3'd4,
        REG_SPD_HYST   = 3'd5,
        REG_ENG_DELAY  = 3'd6,
        REG_RELOCK     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [RpmW-1:0]   min_speed_rpm;
        logic [RpmW-1:0]   max_speed_rpm;
        logic [TpsW-1:0]   throttle_off_point;
        logic [TpsW-1:0]   throttle_hysteresis;
        logic [VssW-1:0]   speed_off_point;
        logic [VssW-1:0]   speed_hysteresis;
        logic [TimerW-1:0] engage_delay;
        logic [TimerW-1:0] relock_delay;
    } t_cfg;

    typedef struct packed {
        logic [TickW-1:0] elapsed_ticks;
        logic             ac_request;
        logic [VssW-1:0]  vehicle_speed;
        logic [TpsW-1:0]  throttle;
        logic [RpmW-1:0]  engine_rpm;
    } t_in;

    typedef struct packed {
        logic              request_latched;
        logic              engaged;
        logic              output_state;
        logic              throttle_hyst_flag;
        logic              speed_hyst_flag;
        logic              hold_flag;
        logic [TimerW-1:0] delay_timer;
        logic [TimerW-1:0] off_timer;
    } t_state;

endpackage

// ===== src/acis_cfg.sv =====
// configuration register file with write-only index port
// depends on acis_pkg
module acis_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [acis_pkg::IdxW-1:0] i_cfg_idx,
    input  logic [acis_pkg::CfgW-1:0] i_cfg_wdata,
    output acis_pkg::t_cfg            o_cfg
);

    acis_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_speed_rpm       <= acis_pkg::RstMinRpm;
            r_cfg.max_speed_rpm       <= acis_pkg::RstMaxRpm;
            r_cfg.throttle_off_point  <= acis_pkg::RstThrOff;
            r_cfg.throttle_hysteresis <= acis_pkg::RstThrHyst;
            r_cfg.speed_off_point     <= acis_pkg::RstSpdOff;
            r_cfg.speed_hysteresis    <= acis_pkg::RstSpdHyst;
            r_cfg.engage_delay        <= acis_pkg::RstEngDelay;
            r_cfg.relock_delay        <= acis_pkg::RstRelock;
        end else if (i_cfg_we) begin
            unique case (acis_pkg::t_reg_idx'(i_cfg_idx))
                acis_pkg::REG_MIN_RPM:   r_cfg.min_speed_rpm <= i_cfg_wdata;
                acis_pkg::REG_MAX_RPM:   r_cfg.max_speed_rpm <= i_cfg_wdata;
                acis_pkg::REG_THR_OFF: begin
                    r_cfg.throttle_off_point <= i_cfg_wdata[acis_pkg::TpsW-1:0];
                end
                acis_pkg::REG_THR_HYST: begin
                    r_cfg.throttle_hysteresis <= i_cfg_wdata[acis_pkg::TpsW-1:0];
                end
                acis_pkg::REG_SPD_OFF:   r_cfg.speed_off_point  <= i_cfg_wdata;
                acis_pkg::REG_SPD_HYST:  r_cfg.speed_hysteresis <= i_cfg_wdata;
                acis_pkg::REG_ENG_DELAY: r_cfg.engage_delay     <= i_cfg_wdata;
                acis_pkg::REG_RELOCK:    r_cfg.relock_delay     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/acis_step.sv =====
// next-state logic for one sample: timer update, limit checks and engage rule
// depends on acis_pkg
module acis_step (
    input  acis_pkg::t_state i_state,
    input  acis_pkg::t_cfg   i_cfg,
    input  acis_pkg::t_in    i_in,
    output acis_pkg::t_state o_state
);

    logic [acis_pkg::TimerW:0]   delay_sum;
    logic [acis_pkg::TimerW:0]   off_sum;
    logic [acis_pkg::TimerW-1:0] delay_sat;
    logic [acis_pkg::TimerW-1:0] off_sat;
    logic [acis_pkg::TpsW:0]     thr_diff;
    logic [acis_pkg::TpsW-1:0]   thr_floor;
    logic [acis_pkg::VssW:0]     spd_diff;
    logic [acis_pkg::VssW-1:0]   spd_floor;
    logic                        speed_on;
    logic                        drop;
    logic                        allow;
    acis_pkg::t_state            n_state;

    // saturating timers
    assign delay_sum = {1'b0, i_state.delay_timer} + {13'd0, i_in.elapsed_ticks};
    assign off_sum   = {1'b0, i_state.off_timer} + {13'd0, i_in.elapsed_ticks};
    assign delay_sat = delay_sum[acis_pkg::TimerW] ? acis_pkg::TimerMax
                                                   : delay_sum[acis_pkg::TimerW-1:0];
    assign off_sat   = off_sum[acis_pkg::TimerW] ? acis_pkg::TimerMax
                                                 : off_sum[acis_pkg::TimerW-1:0];

    // off point minus hysteresis, floored at zero
    assign thr_diff  = {1'b0, i_cfg.throttle_off_point} - {1'b0, i_cfg.throttle_hysteresis};
    assign thr_floor = thr_diff[acis_pkg::TpsW] ? '0 : thr_diff[acis_pkg::TpsW-1:0];
    assign spd_diff  = {1'b0, i_cfg.speed_off_point} - {1'b0, i_cfg.speed_hysteresis};
    assign spd_floor = spd_diff[acis_pkg::VssW] ? '0 : spd_diff[acis_pkg::VssW-1:0];

    assign speed_on = i_cfg.speed_off_point != acis_pkg::SpeedDisabled;
    assign allow    = (i_in.throttle < i_cfg.throttle_off_point)
                   && !(speed_on && (i_in.vehicle_speed > i_cfg.speed_off_point))
                   && (off_sat > i_cfg.relock_delay);

    always_comb begin
        n_state             = i_state;
        n_state.delay_timer = delay_sat;
        n_state.off_timer   = off_sat;
        drop                = 1'b0;
        if (i_in.engine_rpm < i_cfg.min_speed_rpm) begin
            n_state.output_state = 1'b0;
            n_state.off_timer    = '0;
        end else if (i_in.ac_request) begin
            if (i_state.engaged) begin
                if (i_in.throttle > i_cfg.throttle_off_point) begin
                    n_state.throttle_hyst_flag = 1'b1;
                    drop = 1'b1;
                end else if (i_state.throttle_hyst_flag && (i_in.throttle > thr_floor)) begin
                    drop = 1'b1;
                end else begin
                    n_state.throttle_hyst_flag = 1'b0;
                end
                if (speed_on) begin
                    if (i_in.vehicle_speed >= i_cfg.speed_off_point) begin
                        n_state.speed_hyst_flag = 1'b1;
                        drop = 1'b1;
                    end else if (i_state.speed_hyst_flag
                                 && (i_in.vehicle_speed >= spd_floor)) begin
                        drop = 1'b1;
                    end else begin
                        n_state.speed_hyst_flag = 1'b0;
                    end
                end
                if (i_in.engine_rpm > i_cfg.max_speed_rpm) begin
                    drop = 1'b1;
                end
            end
            if (drop) begin
                if (i_state.output_state) begin
                    n_state.off_timer = '0;
                end
                n_state.output_state = 1'b0;
            end else if (allow) begin
                if (!i_state.request_latched) begin
                    n_state.request_latched    = 1'b1;
                    n_state.delay_timer        = '0;
                    n_state.throttle_hyst_flag = 1'b0;
                    n_state.speed_hyst_flag    = 1'b0;
                    n_state.hold_flag          = 1'b1;
                end else if (delay_sat >= i_cfg.engage_delay) begin
                    n_state.output_state = 1'b1;
                    n_state.engaged      = 1'b1;
                    n_state.hold_flag    = 1'b0;
                end
            end
        end else begin
            if (i_state.request_latched) begin
                n_state.request_latched = 1'b0;
                n_state.delay_timer     = '0;
                n_state.off_timer       = '0;
            end else if (delay_sat >= i_cfg.engage_delay) begin
                n_state.output_state = 1'b0;
                n_state.engaged      = 1'b0;
            end
        end
    end

    assign o_state = n_state;

endmodule

// ===== src/ac_idle_up_sequencer.sv =====
// a/c idle-up sequencer top level: input register, step logic, result register
// depends on acis_pkg, acis_cfg, acis_step
// datapath: an accepted input word is held in the input register, then its result in the result register
// throughput: one word per cycle while the receiver takes result words, bounded by the single state update per sample
// reset: synchronous active low, clears all sequencer state and both stage valids
// configuration registers return to their documented defaults on reset
module ac_idle_up_sequencer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [acis_pkg::IdxW-1:0]  i_cfg_idx,
    input  logic [acis_pkg::CfgW-1:0]  i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // engine_rpm[15:0], throttle[25:16], vehicle_speed[41:26], ac_request[42],
    // elapsed_ticks[46:43], zero pad[47]
    input  logic [acis_pkg::InW-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // compressor_on[0], idleup_active[1], pid_hold[2], zero pad[7:3]
    output logic [acis_pkg::OutW-1:0]  o_m_axis_tdata
);

    acis_pkg::t_cfg   cfg;
    acis_pkg::t_in    r_in;
    logic             r_in_valid;
    acis_pkg::t_state r_state;
    acis_pkg::t_state n_state;
    logic             r_out_valid;
    logic [2:0]       r_out;
    logic             adv;
    logic             in_acc;

    acis_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    acis_step u_step (
        .i_state (r_state),
        .i_cfg   (cfg),
        .i_in    (r_in),
        .o_state (n_state)
    );

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= acis_pkg::t_in'(i_s_axis_tdata[46:0]);
        end
        if (adv) begin
            r_out <= {n_state.hold_flag, n_state.request_latched, n_state.output_state};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out};

    a_clutch_needs_engage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.output_state |-> r_state.engaged)
        else $error("clutch driven while not engaged");

    a_state_moves_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(adv)) |-> $stable(r_state))
        else $error("sequencer state changed without a sample");

    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_in_valid)
        else $error("accepted word not held in input register");

endmodule

// ===== tb/sv/ac_idle_up_sequencer_tb.sv =====
// self-checking bench for the a/c idle-up sequencer: named tests drive sample words, a
// behavioural copy of the step rule predicts each clutch word and a monitor compares them
// depends on acis_pkg and ac_idle_up_sequencer
module ac_idle_up_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RpmW   = acis_pkg::RpmW;
    localparam int unsigned TpsW   = acis_pkg::TpsW;
    localparam int unsigned VssW   = acis_pkg::VssW;
    localparam int unsigned TickW  = acis_pkg::TickW;
    localparam int unsigned TimerW = acis_pkg::TimerW;
    localparam int unsigned CfgW   = acis_pkg::CfgW;
    localparam int unsigned IdxW   = acis_pkg::IdxW;
    localparam int unsigned InW    = acis_pkg::InW;
    localparam int unsigned OutW   = acis_pkg::OutW;

    // pid_hold at the top so that compressor_on lands in bit 0
    typedef struct packed {
        logic pid_hold;
        logic idleup_active;
        logic compressor_on;
    } t_clutch_word;

    localparam int unsigned LongHoldCycles = 300;
    localparam int unsigned SettleLimit    = 5000;
    localparam int unsigned DutLatency     = 2;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [IdxW-1:0] cfg_idx   = '0;
    logic [CfgW-1:0] cfg_wdata = '0;
    logic            s_tvalid  = 1'b0;
    logic            s_tready;
    logic [InW-1:0]  s_tdata   = '0;
    logic            m_tvalid;
    logic            m_tready  = 1'b0;
    logic [OutW-1:0] m_tdata;

    acis_pkg::t_cfg   model_cfg;
    acis_pkg::t_state model_st;
    t_clutch_word     pending_words[$];

    int unsigned fail_count      = 0;
    int unsigned words_checked   = 0;
    int unsigned samples_sent    = 0;
    int unsigned settings_loaded = 0;
    int unsigned tx_gap_odds     = 25;
    bit          tx_calm         = 1'b0;
    bit          rx_calm         = 1'b0;
    int unsigned hold_reqs       = 0;
    int unsigned hold_served     = 0;
    int unsigned stall_left      = 0;

    ac_idle_up_sequencer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_clutch_word step_sequencer(input acis_pkg::t_in w);
        logic [TimerW:0]   sum;
        logic              speed_on;
        logic              drop;
        logic [TpsW-1:0]   thr_floor;
        logic [VssW-1:0]   spd_floor;
        t_clutch_word      res;
        sum = model_st.delay_timer + w.elapsed_ticks;
        model_st.delay_timer = sum[TimerW] ? acis_pkg::TimerMax : sum[TimerW-1:0];
        sum = model_st.off_timer + w.elapsed_ticks;
        model_st.off_timer = sum[TimerW] ? acis_pkg::TimerMax : sum[TimerW-1:0];

        speed_on  = model_cfg.speed_off_point != acis_pkg::SpeedDisabled;
        thr_floor = (model_cfg.throttle_hysteresis > model_cfg.throttle_off_point) ? '0 :
                    model_cfg.throttle_off_point - model_cfg.throttle_hysteresis;
        spd_floor = (model_cfg.speed_hysteresis > model_cfg.speed_off_point) ? '0 :
                    model_cfg.speed_off_point - model_cfg.speed_hysteresis;
        drop = 1'b0;

        if (w.engine_rpm < model_cfg.min_speed_rpm) begin
            model_st.output_state = 1'b0;
            model_st.off_timer    = '0;
        end else if (w.ac_request) begin
            if (model_st.engaged) begin
                if (w.throttle > model_cfg.throttle_off_point) begin
                    model_st.throttle_hyst_flag = 1'b1;
                    drop = 1'b1;
                end else if (model_st.throttle_hyst_flag && w.throttle > thr_floor) begin
                    drop = 1'b1;
                end else begin
                    model_st.throttle_hyst_flag = 1'b0;
                end
                if (speed_on) begin
                    if (w.vehicle_speed >= model_cfg.speed_off_point) begin
                        model_st.speed_hyst_flag = 1'b1;
                        drop = 1'b1;
                    end else if (model_st.speed_hyst_flag && w.vehicle_speed >= spd_floor) begin
                        drop = 1'b1;
                    end else begin
                        model_st.speed_hyst_flag = 1'b0;
                    end
                end
                if (w.engine_rpm > model_cfg.max_speed_rpm)
                    drop = 1'b1;
            end
            if (drop) begin
                if (model_st.output_state)
                    model_st.off_timer = '0;
                model_st.output_state = 1'b0;
            end else if (w.throttle < model_cfg.throttle_off_point &&
                         !(speed_on && w.vehicle_speed > model_cfg.speed_off_point) &&
                         model_st.off_timer > model_cfg.relock_delay) begin
                if (!model_st.request_latched) begin
                    model_st.request_latched    = 1'b1;
                    model_st.delay_timer        = '0;
                    model_st.throttle_hyst_flag = 1'b0;
                    model_st.speed_hyst_flag    = 1'b0;
                    model_st.hold_flag          = 1'b1;
                end else if (model_st.delay_timer >= model_cfg.engage_delay) begin
                    model_st.output_state = 1'b1;
                    model_st.engaged      = 1'b1;
                    model_st.hold_flag    = 1'b0;
                end
            end
        end else begin
            if (model_st.request_latched) begin
                model_st.request_latched = 1'b0;
                model_st.delay_timer     = '0;
                model_st.off_timer       = '0;
            end else if (model_st.delay_timer >= model_cfg.engage_delay) begin
                model_st.output_state = 1'b0;
                model_st.engaged      = 1'b0;
            end
        end

        res.compressor_on = model_st.output_state;
        res.idleup_active = model_st.request_latched;
        res.pid_hold      = model_st.hold_flag;
        return res;
    endfunction

    // receiver: random stall bursts, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_reqs != hold_served) begin
            hold_served++;
            stall_left = LongHoldCycles;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_clutch_word want;
        t_clutch_word got;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_clutch_word'(m_tdata[2:0]);
            if (pending_words.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %b", $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (got.compressor_on !== want.compressor_on) begin
                    $display("%0t: compressor_on expected %0b actual %0b",
                             $time, want.compressor_on, got.compressor_on);
                    fail_count++;
                end
                if (got.idleup_active !== want.idleup_active) begin
                    $display("%0t: idleup_active expected %0b actual %0b",
                             $time, want.idleup_active, got.idleup_active);
                    fail_count++;
                end
                if (got.pid_hold !== want.pid_hold) begin
                    $display("%0t: pid_hold expected %0b actual %0b",
                             $time, want.pid_hold, got.pid_hold);
                    fail_count++;
                end
            end
        end
    end

    task automatic offer_sample(input acis_pkg::t_in w);
        int unsigned gap;
        gap = 0;
        if (!tx_calm && tx_gap_odds > 0 && $urandom_range(1, 100) <= tx_gap_odds)
            gap = $urandom_range(1, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= InW'(w);
        do @(posedge clk); while (!s_tready);
        pending_words.push_back(step_sequencer(w));
        samples_sent++;
    endtask

    task automatic send_fields(input int unsigned rpm, input int unsigned tps,
                               input int unsigned vss, input bit req,
                               input int unsigned ticks);
        acis_pkg::t_in w;
        w.engine_rpm    = RpmW'(rpm);
        w.throttle      = TpsW'(tps);
        w.vehicle_speed = VssW'(vss);
        w.ac_request    = req;
        w.elapsed_ticks = TickW'(ticks);
        offer_sample(w);
    endtask

    task automatic settle();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0 && waited < SettleLimit) begin
            @(posedge clk);
            waited++;
        end
        repeat (DutLatency + 2) @(posedge clk);
    endtask

    task automatic write_config(input acis_pkg::t_cfg c);
        acis_pkg::t_reg_idx idx;
        logic [CfgW-1:0]    val;
        for (int r = acis_pkg::REG_MIN_RPM; r <= acis_pkg::REG_RELOCK; r++) begin
            idx = acis_pkg::t_reg_idx'(r);
            case (idx)
                acis_pkg::REG_MIN_RPM:   val = c.min_speed_rpm;
                acis_pkg::REG_MAX_RPM:   val = c.max_speed_rpm;
                acis_pkg::REG_THR_OFF:   val = CfgW'(c.throttle_off_point);
                acis_pkg::REG_THR_HYST:  val = CfgW'(c.throttle_hysteresis);
                acis_pkg::REG_SPD_OFF:   val = c.speed_off_point;
                acis_pkg::REG_SPD_HYST:  val = c.speed_hysteresis;
                acis_pkg::REG_ENG_DELAY: val = c.engage_delay;
                default:                 val = c.relock_delay;
            endcase
            cfg_we    <= 1'b1;
            cfg_idx   <= idx;
            cfg_wdata <= val;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        model_cfg = c;
        settings_loaded++;
    endtask

    function automatic acis_pkg::t_in random_sample(input bit req);
        acis_pkg::t_in w;
        int unsigned   lo;
        int unsigned   hi;
        lo = model_cfg.min_speed_rpm;
        hi = (lo + 3000 > 65535) ? 65535 : lo + 3000;
        w.engine_rpm = RpmW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
                             $urandom_range(lo, hi));
        w.throttle   = TpsW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1000) :
                             $urandom_range(0, model_cfg.throttle_off_point));
        if (model_cfg.speed_off_point != acis_pkg::SpeedDisabled && $urandom_range(0, 4) != 0)
            w.vehicle_speed = VssW'($urandom_range(0, model_cfg.speed_off_point));
        else
            w.vehicle_speed = VssW'($urandom_range(0, 65535));
        w.ac_request    = req;
        w.elapsed_ticks = TickW'($urandom_range(0, 15));
        return w;
    endfunction

    function automatic acis_pkg::t_cfg random_cfg();
        acis_pkg::t_cfg c;
        c.min_speed_rpm       = RpmW'($urandom_range(0, 1500));
        c.max_speed_rpm       = ($urandom_range(0, 1) != 0) ? acis_pkg::RstMaxRpm :
                                RpmW'($urandom_range(2000, 6000));
        c.throttle_off_point  = TpsW'($urandom_range(0, 1000));
        c.throttle_hysteresis = TpsW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000) :
                                      $urandom_range(0, 60));
        c.speed_off_point     = ($urandom_range(0, 2) == 0) ? acis_pkg::SpeedDisabled :
                                VssW'($urandom_range(0, 5000));
        c.speed_hysteresis    = VssW'($urandom_range(0, 2000));
        c.engage_delay        = TimerW'($urandom_range(0, 60));
        c.relock_delay        = TimerW'($urandom_range(0, 30));
        return c;
    endfunction

    // request off runs followed by request on runs, with some toggling noise
    task automatic run_request_runs(input int unsigned n);
        int unsigned sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat (8) begin
                    offer_sample(random_sample($urandom_range(0, 1) != 0));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    offer_sample(random_sample(1'b0));
                    sent++;
                end
                repeat ($urandom_range(1, 25)) begin
                    offer_sample(random_sample(1'b1));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_default_sequence();
        send_fields(0, 0, 0, 0, 15);
        send_fields(65535, 1000, 65535, 1, 0);
        send_fields(1000, 500, 0, 1, 1);
        send_fields(1000, 100, 0, 1, 1);
        send_fields(1000, 100, 0, 1, 15);
        send_fields(1000, 1000, 0, 1, 1);
        send_fields(1000, 490, 0, 1, 1);
        send_fields(1000, 470, 0, 1, 1);
        send_fields(300, 100, 0, 1, 2);
        send_fields(1000, 100, 65535, 1, 2);
        send_fields(1000, 100, 0, 0, 0);
        send_fields(1000, 100, 0, 0, 15);
        send_fields(1000, 100, 0, 1, 3);
        send_fields(1000, 100, 0, 0, 1);
        send_fields(1000, 100, 0, 1, 1);
    endtask

    task automatic test_speed_and_rpm_limits();
        settle();
        write_config('{min_speed_rpm: 16'd400, max_speed_rpm: 16'd4000,
                       throttle_off_point: 10'd500, throttle_hysteresis: 10'd20,
                       speed_off_point: 16'd1000, speed_hysteresis: 16'd100,
                       engage_delay: 16'd0, relock_delay: 16'd0});
        send_fields(1000, 100, 500, 1, 1);
        send_fields(1000, 100, 500, 1, 1);
        send_fields(1000, 100, 1000, 1, 1);
        send_fields(1000, 100, 950, 1, 1);
        send_fields(1000, 100, 850, 1, 1);
        send_fields(5000, 100, 0, 1, 1);
        send_fields(1000, 100, 1001, 1, 2);
        send_fields(1000, 100, 0, 0, 1);
    endtask

    // hysteresis wider than the off point, so the release threshold sits at zero
    task automatic test_hysteresis_floor();
        settle();
        write_config('{min_speed_rpm: 16'd400, max_speed_rpm: 16'd65535,
                       throttle_off_point: 10'd100, throttle_hysteresis: 10'd400,
                       speed_off_point: 16'd500, speed_hysteresis: 16'd3000,
                       engage_delay: 16'd0, relock_delay: 16'd0});
        send_fields(1000, 50, 100, 1, 1);
        send_fields(1000, 50, 100, 1, 1);
        send_fields(1000, 200, 100, 1, 1);
        send_fields(1000, 1, 100, 1, 1);
        send_fields(1000, 0, 100, 1, 1);
        send_fields(1000, 0, 600, 1, 1);
        send_fields(1000, 0, 0, 1, 1);
    endtask

    task automatic test_register_extremes();
        settle();
        write_config('{min_speed_rpm: 16'd0, max_speed_rpm: 16'd65535,
                       throttle_off_point: 10'd1000, throttle_hysteresis: 10'd0,
                       speed_off_point: 16'd0, speed_hysteresis: 16'd0,
                       engage_delay: 16'd0, relock_delay: 16'd0});
        run_request_runs(60);
        settle();
        write_config('{min_speed_rpm: 16'd65535, max_speed_rpm: 16'd0,
                       throttle_off_point: 10'd0, throttle_hysteresis: 10'd1000,
                       speed_off_point: 16'd65534, speed_hysteresis: 16'd65535,
                       engage_delay: 16'd65535, relock_delay: 16'd65535});
        run_request_runs(60);
        settle();
        write_config('{min_speed_rpm: 16'd0, max_speed_rpm: 16'd65535,
                       throttle_off_point: 10'd1000, throttle_hysteresis: 10'd1000,
                       speed_off_point: 16'd65535, speed_hysteresis: 16'd65535,
                       engage_delay: 16'd0, relock_delay: 16'd0});
        run_request_runs(60);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 5; p++) begin
            settle();
            write_config(random_cfg());
            tx_gap_odds = (p == 2) ? 0 : 25;
            rx_calm     = (p == 2);
            run_request_runs(120);
        end
        tx_gap_odds = 25;
        rx_calm     = 1'b0;
    endtask

    // receiver holds off while words keep coming, so the input side backs up
    task automatic test_receiver_hold();
        settle();
        write_config(random_cfg());
        tx_gap_odds = 0;
        hold_reqs++;
        run_request_runs(40);
        tx_gap_odds = 25;
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            run_request_runs(20);
            settle();
        end
    endtask

    // long run of 15-tick samples so the relock wait only runs out late
    task automatic test_long_timers();
        settle();
        write_config('{min_speed_rpm: 16'd400, max_speed_rpm: 16'd65535,
                       throttle_off_point: 10'd500, throttle_hysteresis: 10'd20,
                       speed_off_point: acis_pkg::SpeedDisabled, speed_hysteresis: 16'd0,
                       engage_delay: 16'd0, relock_delay: 16'd2500});
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        for (int i = 0; i < 200; i++)
            send_fields($urandom_range(400, 3400), $urandom_range(0, 499),
                        $urandom_range(0, 65535), i >= 150, 15);
        repeat (3) send_fields(1000, 100, 0, 1, 0);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic test_calm_finish();
        settle();
        write_config(random_cfg());
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_request_runs(100);
    endtask

    initial begin
        model_cfg = '{min_speed_rpm: acis_pkg::RstMinRpm, max_speed_rpm: acis_pkg::RstMaxRpm,
                      throttle_off_point: acis_pkg::RstThrOff,
                      throttle_hysteresis: acis_pkg::RstThrHyst,
                      speed_off_point: acis_pkg::RstSpdOff,
                      speed_hysteresis: acis_pkg::RstSpdHyst,
                      engage_delay: acis_pkg::RstEngDelay, relock_delay: acis_pkg::RstRelock};
        model_st = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_default_sequence();
        test_speed_and_rpm_limits();
        test_hysteresis_floor();
        test_register_extremes();
        test_random_settings();
        test_receiver_hold();
        test_sender_pause();
        test_long_timers();
        test_calm_finish();

        settle();
        repeat (10) @(posedge clk);
        if (pending_words.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending_words.size());
            fail_count += pending_words.size();
        end
        $display("%0d samples sent, %0d clutch words compared, %0d register settings",
                 samples_sent, words_checked, settings_loaded);
        $display("run took in low rpm, limit drops, hysteresis floors, long timer runs and hold-offs");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
